// File: hdl/iredf_pkg.sv
// Package for the IR edge-interval frame decoder.
// Holds widths, register indexes, status codes and the shared structs.
// No dependencies.
package iredf_pkg;

  localparam int FRAME_BITS = 32;              // bit intervals per data frame
  localparam int IV_W       = 16;              // interval tick count width
  localparam int WORD_W     = 32;              // stored frame word width
  localparam int CNT_W      = 6;               // bit counter width
  localparam int BIT_IDX_W  = $clog2(WORD_W);  // index into the frame word
  localparam int REG_IDX_W  = 2;               // configuration index width

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_MIN    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ONE_THRESHOLD = 2'd3;

  // Reset values of the configuration registers
  localparam logic [IV_W-1:0] RST_LEADER_MIN    = 16'd13000;
  localparam logic [IV_W-1:0] RST_LEADER_MAX    = 16'd14000;
  localparam logic [IV_W-1:0] RST_REPEAT_MIN    = 16'd10000;
  localparam logic [IV_W-1:0] RST_ONE_THRESHOLD = 16'd1700;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REPEAT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  // Decoder thresholds
  typedef struct packed {
    logic [IV_W-1:0] leader_min;
    logic [IV_W-1:0] leader_max;
    logic [IV_W-1:0] repeat_min;
    logic [IV_W-1:0] one_threshold;
  } cfg_t;

  // One result from the decode step
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [WORD_W-1:0] frame_word;
  } res_t;

endpackage

// File: hdl/iredf_core.sv
// Decode step of the IR edge-interval frame decoder: phase, bit counter and
// shift word, updated once per processed interval. Depends on iredf_pkg.
module iredf_core
  import iredf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            step,      // process one interval this cycle
  input  logic [IV_W-1:0] interval,
  input  cfg_t            cfg,
  output res_t            res        // result of this step, valid with step
);

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_LEADER = 2'd1,
    PH_READ   = 2'd2
  } phase_t;

  phase_t              phase, phase_next;
  logic [CNT_W-1:0]    bit_count, bit_count_next;
  logic [WORD_W-1:0]   shift_word, shift_word_next;
  logic [CNT_W:0]      count_inc;
  logic [WORD_W-1:0]   word_set;
  logic                leader_ok;

  assign leader_ok = (interval > cfg.leader_min) && (interval < cfg.leader_max);
  assign count_inc = {1'b0, bit_count} + (CNT_W+1)'(1);

  // Set the current bit when the interval is long; drop bits past the word
  always_comb begin
    word_set = shift_word;
    if ((interval > cfg.one_threshold) && ({1'b0, bit_count} < (CNT_W+1)'(WORD_W))) begin
      word_set[bit_count[BIT_IDX_W-1:0]] = 1'b1;
    end
  end

  // Classify the interval by phase
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    res.valid       = 1'b0;
    res.status      = ST_ACCEPT;
    res.frame_word  = '0;
    case (phase)
      PH_LEADER: begin
        if (leader_ok) begin
          phase_next      = PH_READ;
          bit_count_next  = '0;
          shift_word_next = '0;
        end else begin
          res.valid  = 1'b1;
          res.status = (interval > cfg.repeat_min) ? ST_REPEAT : ST_REJECT;
          phase_next = PH_START;
        end
      end
      PH_READ: begin
        if (count_inc >= (CNT_W+1)'(FRAME_BITS)) begin
          res.valid       = 1'b1;
          res.status      = ST_ACCEPT;
          res.frame_word  = word_set;
          phase_next      = PH_START;
          bit_count_next  = '0;
          shift_word_next = '0;
        end else begin
          bit_count_next  = count_inc[CNT_W-1:0];
          shift_word_next = word_set;
        end
      end
      default: begin
        // start edge only opens the leader interval
        phase_next = PH_LEADER;
      end
    endcase
  end

  // Hold state; advance on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      bit_count  <= '0;
      shift_word <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_word <= shift_word_next;
    end
  end

endmodule

// File: hdl/ir_edge_interval_frame_decoder.sv
// IR edge-interval frame decoder: one item per 1 cycle sustained while the output is
// not stalled; an accepted interval goes to the input register, then decode into the
// result register. The result register frees when taken, so a stall only
// blocks input once both registers hold data.
// Reset (rst, synchronous) clears both valid flags, the decode state, and loads
// the threshold registers with their default tick counts.
module ir_edge_interval_frame_decoder
  import iredf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IV_W-1:0]      s_tdata,    // [15:0] interval
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [WORD_W-1:0]    m_tdata,    // [31:0] frame_word
  output logic [1:0]           m_tuser,    // [1:0] status
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [IV_W-1:0]      cfg_wdata
);

  cfg_t            cfg;
  logic            iv_valid;
  logic [IV_W-1:0] iv_data;
  logic            step;
  res_t            res;
  status_t         status_reg;

  // Process the held interval when the result register has room
  assign step     = iv_valid && (!m_tvalid || m_tready);
  assign s_tready = !iv_valid || step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min    <= RST_LEADER_MIN;
      cfg.leader_max    <= RST_LEADER_MAX;
      cfg.repeat_min    <= RST_REPEAT_MIN;
      cfg.one_threshold <= RST_ONE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEADER_MIN:    cfg.leader_min    <= cfg_wdata;
        REG_LEADER_MAX:    cfg.leader_max    <= cfg_wdata;
        REG_REPEAT_MIN:    cfg.repeat_min    <= cfg_wdata;
        REG_ONE_THRESHOLD: cfg.one_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv_valid <= 1'b0;
    end else if (s_tready) begin
      iv_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      iv_data <= s_tdata;
    end
  end

  iredf_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .interval (iv_data),
    .cfg      (cfg),
    .res      (res)
  );

  // Result register: load a new result, drop a taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      status_reg <= res.status;
      m_tdata    <= res.frame_word;
    end
  end

  assign m_tuser = status_reg;

endmodule

// File: hdl/iredf_checker.sv
// Port-level checker for the IR edge-interval frame decoder, bound to the top.
// Depends on iredf_pkg.
module iredf_checker
  import iredf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [WORD_W-1:0] m_tdata,
  input logic [1:0]        m_tuser
);

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_ACCEPT || m_tuser == ST_REPEAT || m_tuser == ST_REJECT))
    else $error("undefined status code");

  // Repeat and reject results carry an empty word
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_ACCEPT |-> m_tdata == '0)
    else $error("nonzero word on repeat or reject");

endmodule

bind ir_edge_interval_frame_decoder iredf_checker u_iredf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: bench/testbench.sv
// Self-checking bench for the IR edge-interval frame decoder.
// Drives edge intervals over the stream input, predicts frame/repeat/reject reports
// and checks them against the stream output. Depends on iredf_pkg and the decoder RTL.
module testbench
  import iredf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT_NS = 4_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_SHOWN    = 10;

  typedef enum int {AWAIT_START, AWAIT_LEADER, READ_BITS} decode_phase_t;

  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] word;
  } frame_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IV_W-1:0]      s_tdata = '0;      // [15:0] interval
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WORD_W-1:0]    m_tdata;           // [31:0] frame_word
  logic [1:0]           m_tuser;           // [1:0] status
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [IV_W-1:0]      cfg_wdata = '0;

  // Edges waiting to be sent and reports the decoder owes us
  logic [IV_W-1:0] edge_queue[$];
  frame_report_t   reports_due[$];
  frame_report_t   report_due;

  // Predictor state and thresholds
  cfg_t              model_cfg;
  decode_phase_t     dec_phase = AWAIT_START;
  int                bit_idx = 0;
  logic [WORD_W-1:0] word_acc = '0;

  // Traffic shaping
  bit   sender_gaps = 1'b0;
  bit   receiver_gaps = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  logic hold_start = 1'b0;
  int   hold_cnt = 0;

  // Bookkeeping
  int mismatch_count = 0;
  int edges_queued = 0;
  int edges_accepted = 0;
  int frames_seen = 0;
  int repeats_seen = 0;
  int rejects_seen = 0;
  int settings_used = 1;

  ir_edge_interval_frame_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the decode state by one edge and queue any report it produces
  task automatic decode_edge(input logic [IV_W-1:0] iv);
    frame_report_t rep;
    case (dec_phase)
      AWAIT_LEADER: begin
        if (iv > model_cfg.leader_min && iv < model_cfg.leader_max) begin
          dec_phase = READ_BITS;
          bit_idx = 0;
          word_acc = '0;
        end else begin
          rep.status = (iv > model_cfg.repeat_min) ? ST_REPEAT : ST_REJECT;
          rep.word = '0;
          reports_due.push_back(rep);
          dec_phase = AWAIT_START;
        end
      end
      READ_BITS: begin
        if (iv > model_cfg.one_threshold && bit_idx < WORD_W) word_acc[bit_idx] = 1'b1;
        bit_idx++;
        if (bit_idx >= FRAME_BITS) begin
          rep.status = ST_ACCEPT;
          rep.word = word_acc;
          reports_due.push_back(rep);
          dec_phase = AWAIT_START;
          bit_idx = 0;
          word_acc = '0;
        end
      end
      default: dec_phase = AWAIT_LEADER;
    endcase
  endtask

  // Sender: hold an item until taken, then predict it and offer the next
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_edge(s_tdata);
        edges_accepted++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the current item
      end else if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (edge_queue.size() != 0) begin
        s_tdata <= edge_queue.pop_front();
        s_tvalid <= 1'b1;
        if (sender_gaps) send_gap = idle_length();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_start) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // Receiver: check each report against the oldest prediction, then pick ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        case (m_tuser)
          ST_ACCEPT: frames_seen++;
          ST_REPEAT: repeats_seen++;
          default:   rejects_seen++;
        endcase
        if (reports_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("ERROR: unexpected report status=%0d word=%08h at %0t",
                     m_tuser, m_tdata, $realtime);
        end else begin
          report_due = reports_due.pop_front();
          if (m_tuser !== report_due.status || m_tdata !== report_due.word) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
              $display({"ERROR: report mismatch at %0t: status exp %0d got %0d, ",
                        "word exp %08h got %08h"},
                       $realtime, report_due.status, m_tuser, report_due.word, m_tdata);
          end
        end
      end
      if (hold_cnt != 0) begin
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (receiver_gaps) stall_left = idle_length();
      end
    end
  end

  task automatic push_edge(input logic [IV_W-1:0] iv);
    edge_queue.push_back(iv);
    edges_queued++;
  endtask

  // Any interval value
  function automatic logic [IV_W-1:0] pick_any();
    return IV_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [IV_W-1:0] pick_above(input logic [IV_W-1:0] t);
    if (t == '1) return '1;
    return IV_W'($urandom_range(int'(t) + 1, 65535));
  endfunction

  // Leader inside the open window, or anything when the window is empty
  function automatic logic [IV_W-1:0] pick_leader();
    if (int'(model_cfg.leader_max) - int'(model_cfg.leader_min) >= 2)
      return IV_W'($urandom_range(int'(model_cfg.leader_min) + 1,
                                  int'(model_cfg.leader_max) - 1));
    return pick_any();
  endfunction

  // Bit interval for a wanted value, often right at the threshold or the extremes
  function automatic logic [IV_W-1:0] pick_bit(input logic b);
    int r;
    r = $urandom_range(0, 3);
    if (b) begin
      if (r == 0) return pick_above(model_cfg.one_threshold) == '1 ? '1 :
                         model_cfg.one_threshold + 1'b1;
      if (r == 1) return '1;
      return pick_above(model_cfg.one_threshold);
    end
    if (r == 0) return model_cfg.one_threshold;
    if (r == 1) return '0;
    return IV_W'($urandom_range(0, int'(model_cfg.one_threshold)));
  endfunction

  // Start edge, leader, then nbits bit intervals of the word
  task automatic push_frame(input logic [WORD_W-1:0] word, input int nbits);
    push_edge(pick_any());
    push_edge(pick_leader());
    for (int i = 0; i < nbits; i++) push_edge(pick_bit(word[i % WORD_W]));
  endtask

  // Drain: sender empty, all reports in, then let the pipe settle
  task automatic wait_idle();
    @(posedge clk);
    while (edge_queue.size() != 0 || s_tvalid || reports_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic start_hold();
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
  endtask

  // Write all four thresholds while the decoder is idle
  task automatic load_thresholds(input cfg_t t);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_LEADER_MIN;
    cfg_wdata <= t.leader_min;
    @(posedge clk);
    cfg_index <= REG_LEADER_MAX;
    cfg_wdata <= t.leader_max;
    @(posedge clk);
    cfg_index <= REG_REPEAT_MIN;
    cfg_wdata <= t.repeat_min;
    @(posedge clk);
    cfg_index <= REG_ONE_THRESHOLD;
    cfg_wdata <= t.one_threshold;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_cfg = t;
    settings_used++;
  endtask

  // Mostly well-formed frames, plus repeats, rejects, cut frames and loose edges
  task automatic random_run(input int n);
    int first;
    int r;
    first = edges_queued;
    while (edges_queued - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        push_frame($urandom, FRAME_BITS);
      end else if (r < 74) begin
        push_edge(pick_any());
        push_edge(pick_above(model_cfg.repeat_min));
      end else if (r < 84) begin
        push_edge(pick_any());
        push_edge(IV_W'($urandom_range(0, int'(model_cfg.repeat_min))));
      end else if (r < 90) begin
        push_frame($urandom, $urandom_range(0, FRAME_BITS - 1));
      end else begin
        push_edge(pick_any());
      end
      if ($urandom_range(0, 24) == 0) wait_idle();
    end
  endtask

  function automatic cfg_t random_thresholds();
    cfg_t t;
    int   span;
    t.leader_min = pick_any();
    span = $urandom_range(2, 6000);
    t.leader_max = (int'(t.leader_min) + span > 65535) ? 16'hFFFF :
                   IV_W'(int'(t.leader_min) + span);
    t.repeat_min = pick_any();
    t.one_threshold = pick_any();
    if ($urandom_range(0, 3) == 0) t.leader_max = pick_any();
    return t;
  endfunction

  initial begin
    cfg_t t;
    model_cfg.leader_min = RST_LEADER_MIN;
    model_cfg.leader_max = RST_LEADER_MAX;
    model_cfg.repeat_min = RST_REPEAT_MIN;
    model_cfg.one_threshold = RST_ONE_THRESHOLD;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed edges at reset thresholds, receiver held off so the pipe backs up
    start_hold();
    push_edge(16'd0);     push_edge(16'd65535);  // repeat, extreme interval
    push_edge(16'd65535); push_edge(16'd0);      // reject, zero interval
    push_edge(16'd1);     push_edge(16'd13000);  // leader equal to minimum
    push_edge(16'd7);     push_edge(16'd14000);  // long leader reports repeat
    push_edge(16'd2);     push_edge(16'd10000);  // at repeat minimum: reject
    push_edge(16'd3);     push_edge(16'd10001);  // just above: repeat
    push_edge(16'd4);     push_edge(16'd13001);  // leader just inside window
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (32'hC3A5_5A3C >> i & 1) push_edge(i % 2 ? 16'd65535 : 16'd1701);
      else push_edge(i % 2 ? 16'd0 : 16'd1700);
    end
    push_edge(16'd5);     push_edge(16'd13999);  // leader at top of window
    for (int i = 0; i < FRAME_BITS; i++) push_edge(i < 16 ? 16'hFFFF : 16'h0000);
    wait_idle();

    // Reset thresholds, idling on both sides
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    random_run(180);

    // All thresholds zero: no frame can start
    t = '0;
    load_thresholds(t);
    sender_gaps = 1'b0;
    random_run(60);

    // All thresholds at maximum: every leader rejected
    t = '1;
    load_thresholds(t);
    receiver_gaps = 1'b0;
    random_run(60);

    // Widest leader window
    t.leader_min = '0;
    t.leader_max = '1;
    t.repeat_min = pick_any();
    t.one_threshold = pick_any();
    load_thresholds(t);
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    random_run(200);

    // Random thresholds, one phase with a second long hold-off
    for (int p = 0; p < 3; p++) begin
      load_thresholds(random_thresholds());
      sender_gaps = p != 1;
      receiver_gaps = p != 2;
      if (p == 1) start_hold();
      random_run(130);
    end

    wait_idle();
    $display("Covered %0d edges over %0d threshold settings:", edges_accepted, settings_used);
    $display("  %0d frames, %0d repeats, %0d rejects reported", frames_seen, repeats_seen,
             rejects_seen);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Hard stop if the decoder hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d reports outstanding", reports_due.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
